[src/iqs_pkg.sv]
`default_nettype none
package iqs_pkg;

  localparam int FracBits  = 15;
  localparam int MaxHaps   = 65536;
  localparam int CntW      = 17;
  localparam int QW        = 16;
  localparam logic [QW-1:0] OneQ  = QW'(1) << FracBits;
  localparam logic [QW-1:0] HalfQ = OneQ >> 1;

  // divider width: the empirical R2 denominator vx*vy and the squared cross
  // term stay below 2^91 for up to MaxHaps elements
  localparam int DivW = 96;

  // accumulated sums of one variant, handed from front to back
  typedef struct packed {
    logic [CntW-1:0] n;
    logic [31:0]     sx;
    logic [47:0]     sxx;
    logic [31:0]     scs;
    logic [31:0]     lsx;
    logic [47:0]     lsxx;
    logic [CntW-1:0] sobs;
    logic [31:0]     scross;
    logic            typed;
    logic            has_loo;
  } sums_t;

  typedef struct packed {
    logic [QW-1:0]   allele_freq;
    logic [QW-2:0]   minor_freq;
    logic [QW-1:0]   avg_call_score;
    logic [QW-1:0]   r_squared;
    logic [QW-1:0]   empirical_r_squared;
    logic            typed_flag;
    logic            imputed_flag;
    logic            keep;
    logic [CntW-1:0] present_count;
  } result_t;

endpackage
`default_nettype wire

[src/iqs_front.sv]
`default_nettype none
// Accumulates one element per cycle while the queue is not full; on last pushes the sums into the queue.
module iqs_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire [15:0]          dosage,
  input  wire                 absent,
  input  wire                 typed,
  input  wire                 has_loo,
  input  wire [15:0]          loo_dose,
  input  wire                 observed,
  input  wire                 last,
  output logic                push,
  output iqs_pkg::sums_t      push_data,
  input  wire                 q_full
);

  logic [iqs_pkg::CntW-1:0] n_r;
  logic [31:0] sx_r, scs_r, lsx_r, scross_r;
  logic [47:0] sxx_r, lsxx_r;
  logic [iqs_pkg::CntW-1:0] sobs_r;

  logic [15:0] x, lx, cs;
  logic [31:0] xx, lxx;
  logic        add;
  logic [iqs_pkg::CntW-1:0] n_nxt, sobs_nxt;
  logic [31:0] sx_nxt, scs_nxt, lsx_nxt, scross_nxt;
  logic [47:0] sxx_nxt, lsxx_nxt;
  logic        acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    x   = (dosage > iqs_pkg::OneQ) ? iqs_pkg::OneQ : dosage;
    lx  = (loo_dose > iqs_pkg::OneQ) ? iqs_pkg::OneQ : loo_dose;
    xx  = x * x;
    lxx = lx * lx;
    cs  = (x > iqs_pkg::HalfQ) ? x : iqs_pkg::OneQ - x;
    add = !absent && (n_r < iqs_pkg::CntW'(iqs_pkg::MaxHaps));
    n_nxt = n_r; sx_nxt = sx_r; sxx_nxt = sxx_r; scs_nxt = scs_r;
    lsx_nxt = lsx_r; lsxx_nxt = lsxx_r; sobs_nxt = sobs_r; scross_nxt = scross_r;
    if (add) begin
      n_nxt   = n_r + 1'b1;
      sx_nxt  = sx_r + 32'(x);
      sxx_nxt = sxx_r + 48'(xx);
      scs_nxt = scs_r + 32'(cs);
      if (has_loo) begin
        lsx_nxt    = lsx_r + 32'(lx);
        lsxx_nxt   = lsxx_r + 48'(lxx);
        sobs_nxt   = sobs_r + iqs_pkg::CntW'(observed);
        scross_nxt = scross_r + (observed ? 32'(lx) : 32'd0);
      end
    end
  end

  always_comb begin
    push                   = acc && last;
    push_data.n            = n_nxt;
    push_data.sx           = sx_nxt;
    push_data.sxx          = sxx_nxt;
    push_data.scs          = scs_nxt;
    push_data.lsx          = lsx_nxt;
    push_data.lsxx         = lsxx_nxt;
    push_data.sobs         = sobs_nxt;
    push_data.scross       = scross_nxt;
    push_data.typed        = typed;
    push_data.has_loo      = has_loo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && last)) begin
      n_r <= '0; sx_r <= '0; sxx_r <= '0; scs_r <= '0;
      lsx_r <= '0; lsxx_r <= '0; sobs_r <= '0; scross_r <= '0;
    end else if (acc) begin
      n_r <= n_nxt; sx_r <= sx_nxt; sxx_r <= sxx_nxt; scs_r <= scs_nxt;
      lsx_r <= lsx_nxt; lsxx_r <= lsxx_nxt; sobs_r <= sobs_nxt;
      scross_r <= scross_nxt;
    end
  end

endmodule
`default_nettype wire

[src/iqs_fifo.sv]
`default_nettype none
// Two-entry queue of per-variant sums.
module iqs_fifo (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  iqs_pkg::sums_t      push_data,
  output logic                full,
  input  wire                 pop,
  output logic                empty,
  output iqs_pkg::sums_t      pop_data
);

  iqs_pkg::sums_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

[src/iqs_div.sv]
`default_nettype none
// Restoring divider: q = floor(ONE*num/den) saturated at ONE, zero for den zero.
// One quotient bit per cycle.
module iqs_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire [iqs_pkg::DivW-1:0]    num,
  input  wire [iqs_pkg::DivW-1:0]    den,
  output logic                       done,
  output logic [iqs_pkg::QW-1:0]     quo
);

  logic [iqs_pkg::DivW:0]   rem_r;
  logic [iqs_pkg::DivW-1:0] den_r;
  logic [iqs_pkg::QW-1:0]   q_r;
  logic [4:0]               cnt_r;
  logic                     busy_r;
  logic [iqs_pkg::DivW:0]   sh;
  logic                     ge;

  assign sh   = {rem_r[iqs_pkg::DivW-1:0], 1'b0};
  assign ge   = (sh >= {1'b0, den_r});
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0; cnt_r <= '0; q_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_r <= den;
        rem_r <= {1'b0, num};
        q_r   <= '0;
        cnt_r <= 5'(iqs_pkg::FracBits);
        if (den == '0) begin
          done <= 1'b1;
        end else if (num >= den) begin
          q_r  <= iqs_pkg::OneQ;
          done <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? sh - {1'b0, den_r} : sh;
        q_r   <= {q_r[iqs_pkg::QW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[src/iqs_back.sv]
`default_nettype none
// Sequencer: builds numerator/denominator for each ratio (for the R2 ratios with
// multi-cycle partial-product multiplies), then runs the shared divider.
module iqs_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire signed [16:0]      min_r2,
  input  wire                    q_empty,
  input  iqs_pkg::sums_t         q_data,
  output logic                   pop,
  output logic                   res_valid,
  input  wire                    res_ready,
  output iqs_pkg::result_t       res
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD,
    S_AF, S_AF_W, S_CS, S_CS_W,
    S_R2A, S_R2B, S_R2C, S_R2D, S_R2_W,
    S_EA, S_EB, S_EC, S_ED, S_EE, S_EF, S_EG, S_EH, S_EI, S_EJ, S_EK, S_EL,
    S_E_W,
    S_OUT
  } state_t;

  localparam int W = iqs_pkg::DivW;

  state_t           st_r;
  iqs_pkg::sums_t   s_r;
  logic [W-1:0]     a_r, b_r, num_r, den_r;
  logic [63:0]      vy_r, d_r;
  logic [iqs_pkg::QW-1:0] af_r, cs_r, r2_r, er2_r;
  logic             r2_zero_r;
  logic [W-1:0]     t_r;

  // one 32x32 multiplier shared over steps
  logic [31:0]      ma, mb;
  logic [63:0]      mp;
  assign mp = ma * mb;

  logic             dstart;
  logic [W-1:0]     dnum, dden;
  logic             ddone;
  logic [iqs_pkg::QW-1:0] dquo;

  iqs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  logic [iqs_pkg::QW-1:0] maf;
  logic                    keep;
  always_comb begin
    maf  = (af_r > iqs_pkg::HalfQ) ? iqs_pkg::OneQ - af_r : af_r;
    keep = min_r2[16] || ({1'b0, r2_r} >= min_r2[16:0]);
  end

  // operand selection for the shared multiplier
  always_comb begin
    ma = '0; mb = '0;
    case (st_r)
      S_R2A:  begin ma = 32'(s_r.n); mb = s_r.sxx[31:0]; end
      S_R2B:  begin ma = 32'(s_r.n); mb = 32'(s_r.sxx[47:32]); end
      S_R2C:  begin ma = s_r.sx; mb = s_r.sx; end
      S_R2D:  begin ma = s_r.sx; mb = t_r[31:0]; end
      S_EA:   begin ma = 32'(s_r.n); mb = s_r.lsxx[31:0]; end
      S_EB:   begin ma = 32'(s_r.n); mb = 32'(s_r.lsxx[47:32]); end
      S_EC:   begin ma = s_r.lsx; mb = s_r.lsx; end
      S_ED:   begin ma = 32'(s_r.n); mb = 32'(s_r.sobs); end
      S_EE:   begin ma = 32'(s_r.sobs); mb = 32'(s_r.sobs); end
      S_EF:   begin ma = 32'(s_r.n); mb = s_r.scross; end
      S_EG:   begin ma = s_r.lsx; mb = 32'(s_r.sobs); end
      // den = vx * vy in two halves of vx
      S_EH:   begin ma = num_r[31:0]; mb = vy_r[31:0]; end
      S_EI:   begin ma = num_r[63:32]; mb = vy_r[31:0]; end
      // d * d with d split at bit 32
      S_EJ:   begin ma = d_r[31:0]; mb = d_r[31:0]; end
      S_EK:   begin ma = d_r[31:0]; mb = 32'(d_r[47:32]); end
      S_EL:   begin ma = 32'(d_r[47:32]); mb = 32'(d_r[47:32]); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign pop = (st_r == S_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; res_valid <= 1'b0; dstart <= 1'b0;
    end else begin
      dstart <= 1'b0;
      case (st_r)
        S_IDLE: if (!q_empty && !res_valid) st_r <= S_LOAD;
        S_LOAD: begin
          s_r <= q_data;
          st_r <= S_AF;
        end
        S_AF: begin
          // sum_x / n scaled: num = sx, den = n*ONE; q = floor(ONE*sx/(n*ONE))
          dnum <= W'(s_r.sx);
          dden <= W'({s_r.n, {iqs_pkg::FracBits{1'b0}}});
          dstart <= 1'b1; st_r <= S_AF_W;
        end
        S_AF_W: if (ddone) begin af_r <= dquo; st_r <= S_CS; end
        S_CS: begin
          dnum <= W'(s_r.scs);
          dden <= W'({s_r.n, {iqs_pkg::FracBits{1'b0}}});
          dstart <= 1'b1; st_r <= S_CS_W;
        end
        S_CS_W: if (ddone) begin cs_r <= dquo; st_r <= S_R2A; end
        S_R2A: begin
          a_r <= W'(mp);
          r2_zero_r <= (s_r.n == '0) || (s_r.sx == '0) ||
                       (s_r.sx >= {s_r.n, {iqs_pkg::FracBits{1'b0}}});
          t_r <= W'({s_r.n, {iqs_pkg::FracBits{1'b0}}}) - W'(s_r.sx);
          st_r <= S_R2B;
        end
        S_R2B: begin a_r <= a_r + (W'(mp) << 32); st_r <= S_R2C; end
        S_R2C: begin b_r <= W'(mp); st_r <= S_R2D; end
        S_R2D: begin
          dnum <= (a_r < b_r) ? '0 : a_r - b_r;
          dden <= r2_zero_r ? '0 : W'(mp);
          dstart <= 1'b1; st_r <= S_R2_W;
        end
        S_R2_W: if (ddone) begin
          r2_r <= dquo;
          if (s_r.has_loo && s_r.n != '0) st_r <= S_EA;
          else begin er2_r <= '0; st_r <= S_OUT; end
        end
        S_EA: begin a_r <= W'(mp); st_r <= S_EB; end
        S_EB: begin a_r <= a_r + (W'(mp) << 32); st_r <= S_EC; end
        S_EC: begin
          num_r <= (a_r < W'(mp)) ? '0 : a_r - W'(mp);  // vx
          st_r <= S_ED;
        end
        S_ED: begin vy_r <= mp; st_r <= S_EE; end
        S_EE: begin
          vy_r <= (vy_r < mp) ? '0 : vy_r - mp;
          st_r <= S_EF;
        end
        S_EF: begin d_r <= mp; st_r <= S_EG; end
        S_EG: begin
          d_r <= (d_r < mp) ? mp - d_r : d_r - mp;
          st_r <= S_EH;
        end
        // vx < 2^63, vy < 2^31, d < 2^48
        S_EH: begin den_r <= W'(mp); st_r <= S_EI; end
        S_EI: begin den_r <= den_r + (W'(mp) << 32); st_r <= S_EJ; end
        S_EJ: begin num_r <= W'(mp); st_r <= S_EK; end
        S_EK: begin num_r <= num_r + (W'(mp) << 33); st_r <= S_EL; end
        S_EL: begin
          dnum <= num_r + (W'(mp) << 64);
          dden <= den_r;
          dstart <= 1'b1; st_r <= S_E_W;
        end
        S_E_W: if (ddone) begin er2_r <= dquo; st_r <= S_OUT; end
        S_OUT: begin
          res.allele_freq         <= (s_r.n == '0) ? '0 : af_r;
          res.minor_freq          <= (s_r.n == '0) ? '0 : maf[iqs_pkg::QW-2:0];
          res.avg_call_score      <= (s_r.n == '0) ? '0 : cs_r;
          res.r_squared           <= r2_r;
          res.empirical_r_squared <= er2_r;
          res.typed_flag          <= s_r.typed;
          res.imputed_flag        <= s_r.has_loo || !s_r.typed;
          res.keep                <= keep;
          res.present_count       <= s_r.n;
          res_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (res_valid && res_ready) res_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[src/imputation_quality_stats.sv]
`default_nettype none
// With leave-one-out data (and n nonzero) the back also computes empirical_r_squared.
// The front takes one word per cycle while in_tready is high; the back works on one
// variant at a time, so short variants fill the two-entry queue and drop in_tready.
// Reset (rst_n low, synchronous) clears sums, queue and min_r2 to -32768.
module imputation_quality_stats (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire [16:0]  cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [39:0]  in_tdata,   // dosage[15:0], absent, typed, has_loo, loo_dose, observed
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [103:0] out_tdata  // allele_freq, minor_freq, avg_call_score, r_squared,
                                  // empirical_r_squared, typed_flag, imputed_flag, keep,
                                  // present_count
);

  logic signed [16:0] min_r2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) min_r2_r <= -17'sd32768;
    else if (cfg_we) min_r2_r <= cfg_wdata;
  end

  logic           push, full, empty, pop;
  iqs_pkg::sums_t push_data, pop_data;
  iqs_pkg::result_t res;

  iqs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .dosage(in_tdata[15:0]), .absent(in_tdata[16]), .typed(in_tdata[17]),
    .has_loo(in_tdata[18]), .loo_dose(in_tdata[34:19]), .observed(in_tdata[35]),
    .last(in_tlast), .push(push), .push_data(push_data), .q_full(full)
  );

  iqs_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .empty(empty), .pop_data(pop_data)
  );

  iqs_back u_back (
    .clk(clk), .rst_n(rst_n), .min_r2(min_r2_r), .q_empty(empty), .q_data(pop_data),
    .pop(pop), .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {5'd0, res.present_count, res.keep, res.imputed_flag,
                      res.typed_flag, res.empirical_r_squared, res.r_squared,
                      res.avg_call_score, res.minor_freq, res.allele_freq};

endmodule
`default_nettype wire

[src/iqs_checker.sv]
`default_nettype none
module iqs_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [103:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_af: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] <= 16'd32768)
    else $error("allele_freq above one");

  a_r2: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[62:47] <= 16'd32768)
    else $error("r_squared above one");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[98:82] == 17'd0 |-> out_tdata[15:0] == 16'd0)
    else $error("nonzero freq for empty variant");

endmodule

bind imputation_quality_stats iqs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
